FILE: hdl/lgrs_pkg.sv
package lgrs_pkg;

    localparam int ROW_W      = 64;
    localparam int CFG_W      = 7;
    localparam int GRID_WIDTH = 64;
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_LW    = $clog2(OUTQ_DEPTH + 1);

    localparam logic [CFG_W-1:0] WIDTH_RESET = 7'd64;
    localparam logic [3:0]       BIRTH_COUNT = 4'd3;
    localparam logic [3:0]       CROWD_LIMIT = 4'd4;

    // Masked bits that one column cell shows to its two neighbours.
    typedef struct packed {
        logic above;
        logic held;
        logic cur;
        logic up2;
    } t_tap;

    typedef struct packed {
        logic en;
        logic last;
        logic holding;
    } t_cell_ctl;

    typedef struct packed {
        logic [ROW_W-1:0] cells;
        logic             last;
    } t_result;

    typedef struct packed {
        logic               space_ok;
        logic [OUTQ_LW-1:0] level;
    } t_q_stat;

    function automatic logic life_rule(input logic alive, input logic [3:0] n);
        logic born;
        logic lives;
        born  = !alive && (n == BIRTH_COUNT);
        lives = alive && (n > 4'd1) && (n < CROWD_LIMIT);
        return born || lives;
    endfunction

endpackage

FILE: hdl/lgrs_cell.sv
module lgrs_cell
    import lgrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_live,
    input  logic      i_cur,
    input  t_tap      i_left,
    input  t_tap      i_right,
    output t_tap      o_tap,
    output logic      o_res_held,
    output logic      o_res_cur
);

    logic r_above;
    logic r_held;
    logic n_above;
    logic n_held;
    logic [3:0] w_n_held;
    logic [3:0] w_n_cur;

    always_comb begin
        o_tap.above = r_above & i_live;
        o_tap.held  = r_held & i_live;
        o_tap.cur   = i_cur & i_live;
        o_tap.up2   = i_ctl.holding ? (r_held & i_live) : (r_above & i_live);
    end

    // Held row against the stored row above and the incoming row below.
    assign w_n_held = {3'b0, i_left.above} + {3'b0, o_tap.above} + {3'b0, i_right.above}
                    + {3'b0, i_left.held} + {3'b0, i_right.held}
                    + {3'b0, i_left.cur} + {3'b0, o_tap.cur} + {3'b0, i_right.cur};

    // Incoming bottom row, with a dead row below it.
    assign w_n_cur = {3'b0, i_left.up2} + {3'b0, o_tap.up2} + {3'b0, i_right.up2}
                   + {3'b0, i_left.cur} + {3'b0, i_right.cur};

    assign o_res_held = life_rule(o_tap.held, w_n_held) & i_live;
    assign o_res_cur  = life_rule(o_tap.cur, w_n_cur) & i_live;

    always_comb begin
        n_above = r_above;
        n_held  = r_held;
        if (i_ctl.en) begin
            if (i_ctl.last) begin
                n_above = 1'b0;
                n_held  = 1'b0;
            end else begin
                n_above = i_ctl.holding ? r_held : r_above;
                n_held  = i_cur & i_live;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above <= 1'b0;
            r_held  <= 1'b0;
        end else begin
            r_above <= n_above;
            r_held  <= n_held;
        end
    end

endmodule

FILE: hdl/lgrs_outq.sv
module lgrs_outq
    import lgrs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_result i_entry0,
    input  t_result i_entry1,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_head,
    output t_q_stat o_stat
);

    t_result r_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_wp;
    logic [OUTQ_AW-1:0] r_rp;
    logic [OUTQ_LW-1:0] r_level;
    logic [OUTQ_AW-1:0] n_wp;
    logic [OUTQ_AW-1:0] n_rp;
    logic [OUTQ_LW-1:0] n_level;
    logic w_pop;

    assign o_valid = (r_level != '0);
    assign o_head  = r_mem[r_rp];
    assign w_pop   = o_valid && i_ready;

    // Room for the two results a bottom row may bring, ignoring this cycle's pop.
    assign o_stat.space_ok = (r_level <= OUTQ_LW'(OUTQ_DEPTH - 2));
    assign o_stat.level    = r_level;

    always_comb begin
        n_wp    = r_wp + OUTQ_AW'(i_push_n);
        n_rp    = r_rp + OUTQ_AW'(w_pop);
        n_level = r_level + OUTQ_LW'(i_push_n) - OUTQ_LW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_entry0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wp + OUTQ_AW'(1)] <= i_entry1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_level <= n_level;
        end
    end

endmodule

FILE: hdl/life_generation_row_stepper_core.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-------------------------------------
// in       | i_in_valid / o_in_ready   | i_row_cells, i_last_row_in
// out      | o_out_valid / i_out_ready | o_next_row_cells, o_last_row_out
// cfg      | i_cfg_we (no wait)        | i_cfg_wdata (width in use)
//
// One row transaction is taken per cycle while o_in_ready is high; its results
// reach the output queue as it is accepted and are presented from the next one.
// A bottom row that follows a held row yields two results, which leave the
// queue one after the other; a bottom row with no held row yields one.
// The input stalls only when the four-entry output queue has fewer than two
// free places. Synchronous active-low reset empties the queue and clears
// the stored rows; the width register resets to 64.
module life_generation_row_stepper_core
    import lgrs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [ROW_W-1:0] i_row_cells,
    input  logic             i_last_row_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ROW_W-1:0] o_next_row_cells,
    output logic             o_last_row_out
);

    logic [CFG_W-1:0] r_width;
    logic             r_holding;
    logic             n_holding;
    logic             w_in_acc;
    logic [ROW_W-1:0] w_live;
    logic [ROW_W-1:0] w_res_held;
    logic [ROW_W-1:0] w_res_cur;
    t_tap             w_tap [ROW_W];
    t_cell_ctl        w_ctl;
    t_result          w_entry0;
    t_result          w_entry1;
    t_result          w_head;
    t_q_stat          w_qstat;
    logic [1:0]       w_push_n;

    assign o_in_ready = w_qstat.space_ok;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_ctl.en      = w_in_acc;
    assign w_ctl.last    = i_last_row_in;
    assign w_ctl.holding = r_holding;

    for (genvar k = 0; k < ROW_W; k++) begin : g_col
        localparam bit COL_EXISTS = (k < GRID_WIDTH);
        t_tap w_left;
        t_tap w_right;

        assign w_live[k] = COL_EXISTS && (r_width > 7'(k));
        assign w_left    = (k == 0) ? '0 : w_tap[(k == 0) ? 0 : k - 1];
        assign w_right   = (k == ROW_W - 1) ? '0 : w_tap[(k == ROW_W - 1) ? k : k + 1];

        lgrs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_live     (w_live[k]),
            .i_cur      (i_row_cells[k]),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_tap      (w_tap[k]),
            .o_res_held (w_res_held[k]),
            .o_res_cur  (w_res_cur[k])
        );
    end

    // Without a held row, the only result is the bottom row's own one.
    always_comb begin
        w_entry0.cells = r_holding ? w_res_held : w_res_cur;
        w_entry0.last  = !r_holding;
        w_entry1.cells = w_res_cur;
        w_entry1.last  = 1'b1;
        w_push_n       = w_in_acc ? ({1'b0, r_holding} + {1'b0, i_last_row_in}) : 2'd0;
    end

    lgrs_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_entry0 (w_entry0),
        .i_entry1 (w_entry1),
        .i_ready  (i_out_ready),
        .o_valid  (o_out_valid),
        .o_head   (w_head),
        .o_stat   (w_qstat)
    );

    assign o_next_row_cells = w_head.cells;
    assign o_last_row_out   = w_head.last;

    always_comb begin
        n_holding = r_holding;
        if (w_in_acc) begin
            n_holding = !i_last_row_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RESET;
            r_holding <= 1'b0;
        end else begin
            r_holding <= n_holding;
            if (i_cfg_we) begin
                r_width <= i_cfg_wdata;
            end
        end
    end

    a_last_clears_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last_row_in) |=> !r_holding)
        else $error("held row survived the bottom row");

    a_result_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (r_holding || i_last_row_in)) |=> o_out_valid)
        else $error("result not presented after a producing transaction");

    a_queue_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.level <= OUTQ_LW'(OUTQ_DEPTH))
        else $error("output queue overflow");

    a_two_results : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_holding && i_last_row_in)
            |=> (w_qstat.level >= OUTQ_LW'(2)))
        else $error("bottom row lost one of its two results");

endmodule

FILE: sim/tb.sv
module tb;
    import lgrs_pkg::*;

    localparam int BORN_ON    = 3;
    localparam int CROWDED_AT = 4;
    localparam int LONG_HOLD  = 400;
    localparam int RANDOM_ROWS = 1750;

    typedef enum logic {
        STIM_ROW,
        STIM_WIDTH
    } t_stim_kind;

    typedef struct {
        t_stim_kind       kind;
        logic [ROW_W-1:0] cells;
        logic             last;
        logic [CFG_W-1:0] width;
        bit               known;
        logic [ROW_W-1:0] known_cells;
    } t_stim;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [ROW_W-1:0] i_row_cells;
    logic             i_last_row_in;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [ROW_W-1:0] o_next_row_cells;
    logic             o_last_row_out;

    // Shadow of the block: width register and the two stored rows.
    logic [CFG_W-1:0] width_reg;
    logic [ROW_W-1:0] row_above_q;
    logic [ROW_W-1:0] row_held_q;
    logic             holding_q;

    t_result pending_results[$];
    t_stim   directed_rows[$];

    int  mismatches       = 0;
    int  rows_sent        = 0;
    int  results_checked  = 0;
    int  generations_done = 0;
    int  width_writes     = 0;
    int  hold_cycles_seen = 0;
    bit  send_calm        = 1'b0;
    bit  recv_calm        = 1'b0;

    life_generation_row_stepper_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_row_cells      (i_row_cells),
        .i_last_row_in    (i_last_row_in),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_next_row_cells (o_next_row_cells),
        .o_last_row_out   (o_last_row_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [ROW_W-1:0] live_mask();
        int w;
        w = (width_reg > GRID_WIDTH) ? GRID_WIDTH : int'(width_reg);
        return (w >= ROW_W) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic [ROW_W-1:0] next_generation_row(input logic [ROW_W-1:0] up,
                                                             input logic [ROW_W-1:0] mid,
                                                             input logic [ROW_W-1:0] down);
        logic [ROW_W-1:0] m;
        logic [ROW_W-1:0] res;
        int               n;
        int               idx;
        m    = live_mask();
        up   = up & m;
        mid  = mid & m;
        down = down & m;
        res  = '0;
        for (int k = 0; k < ROW_W; k++) begin
            n = 0;
            for (int dk = -1; dk <= 1; dk++) begin
                idx = k + dk;
                if (idx >= 0 && idx < ROW_W) begin
                    n += up[idx] + down[idx];
                    if (dk != 0)
                        n += mid[idx];
                end
            end
            if (mid[k])
                res[k] = (n > 1) && (n < CROWDED_AT);
            else
                res[k] = (n == BORN_ON);
        end
        return res & m;
    endfunction

    // Works out the results of one accepted row and queues them. A typed value in
    // the stimulus replaces the bottom result of a last row, else the held row's.
    function automatic void advance_grid(input logic [ROW_W-1:0] cells, input logic last,
                                         input bit known, input logic [ROW_W-1:0] known_cells);
        logic [ROW_W-1:0] cur;
        t_result          r;
        cur = cells & live_mask();
        if (holding_q) begin
            r.cells = next_generation_row(row_above_q, row_held_q, cur);
            r.last  = 1'b0;
            if (known && !last)
                r.cells = known_cells;
            pending_results.push_back(r);
            row_above_q = row_held_q;
        end
        row_held_q = cur;
        holding_q  = 1'b1;
        if (last) begin
            r.cells = next_generation_row(row_above_q, row_held_q, '0);
            r.last  = 1'b1;
            if (known)
                r.cells = known_cells;
            pending_results.push_back(r);
            row_above_q = '0;
            row_held_q  = '0;
            holding_q   = 1'b0;
            generations_done++;
        end
    endfunction

    function automatic int pick_pause(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ROW_W-1:0] random_row(input int style);
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        logic [ROW_W-1:0] c;
        a = {$urandom(), $urandom()};
        b = {$urandom(), $urandom()};
        c = {$urandom(), $urandom()};
        case (style)
            0, 1: begin
                return a;
            end
            2: begin
                return a & b & c;
            end
            3: begin
                return a | b;
            end
            4: begin
                return ($urandom_range(0, 1) == 0) ? '0 : '1;
            end
            default: begin
                return a & b;
            end
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_width();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 7'd64;
        if (r < 6)
            return CFG_W'($urandom_range(1, 64));
        if (r == 6)
            return CFG_W'($urandom_range(1, 5));
        if (r == 7)
            return 7'd63;
        if (r == 8)
            return CFG_W'($urandom_range(65, 127));
        return 7'd0;
    endfunction

    function automatic t_stim row_entry(input logic [ROW_W-1:0] c, input logic l);
        t_stim s;
        s = '{STIM_ROW, c, l, '0, 1'b0, '0};
        return s;
    endfunction

    function automatic t_stim known_entry(input logic [ROW_W-1:0] c, input logic l,
                                          input logic [ROW_W-1:0] e);
        t_stim s;
        s = '{STIM_ROW, c, l, '0, 1'b1, e};
        return s;
    endfunction

    function automatic t_stim width_entry(input logic [CFG_W-1:0] w);
        t_stim s;
        s = '{STIM_WIDTH, '0, 1'b0, w, 1'b0, '0};
        return s;
    endfunction

    task automatic flag_mismatch(input string what, input logic [ROW_W-1:0] got,
                                 input logic [ROW_W-1:0] want);
        if (mismatches < 50)
            $display("%0t: %s mismatch, got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance, with valid still high.
    task automatic push_row(input logic [ROW_W-1:0] cells, input logic last, input bit known,
                            input logic [ROW_W-1:0] known_cells);
        int gap;
        gap = pick_pause(send_calm);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_row_cells   = cells;
        i_last_row_in = last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        advance_grid(cells, last, known, known_cells);
        rows_sent++;
        @(negedge i_clk);
    endtask

    // The width may only change once the output side has drained; a row that
    // is merely stored gives no result, so a few cycles more are allowed.
    task automatic set_width(input logic [CFG_W-1:0] w);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = w;
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        width_reg = w;
        width_writes++;
    endtask

    initial begin
        int        remaining;
        int        height;
        int        style;
        t_stim     s;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_row_cells   = '0;
        i_last_row_in = 1'b0;
        width_reg     = WIDTH_RESET;
        row_above_q   = '0;
        row_held_q    = '0;
        holding_q     = 1'b0;

        directed_rows.push_back(known_entry('1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE));
        directed_rows.push_back(known_entry('0, 1'b1, '0));
        directed_rows.push_back(known_entry(64'h7, 1'b1, 64'h2));
        directed_rows.push_back(row_entry(64'h2, 1'b0));
        directed_rows.push_back(known_entry(64'h2, 1'b0, '0));
        directed_rows.push_back(row_entry(64'h2, 1'b1));
        directed_rows.push_back(row_entry(64'hC000_0000_0000_0003, 1'b0));
        directed_rows.push_back(row_entry(64'hC000_0000_0000_0003, 1'b1));
        directed_rows.push_back(row_entry(64'hA5A5_5A5A_F00F_0FF0, 1'b0));
        directed_rows.push_back(row_entry(64'h5A5A_A5A5_0FF0_F00F, 1'b0));
        directed_rows.push_back(row_entry('1, 1'b0));
        // Narrowing in the middle of a generation keeps the stored rows.
        directed_rows.push_back(width_entry(7'd4));
        directed_rows.push_back(row_entry('1, 1'b0));
        directed_rows.push_back(row_entry('1, 1'b1));
        directed_rows.push_back(width_entry(7'd0));
        directed_rows.push_back(known_entry('1, 1'b1, '0));
        directed_rows.push_back(width_entry(7'd1));
        directed_rows.push_back(known_entry('1, 1'b1, '0));
        directed_rows.push_back(width_entry(7'd3));
        directed_rows.push_back(known_entry('1, 1'b1, 64'h2));
        directed_rows.push_back(width_entry(7'd127));
        directed_rows.push_back(known_entry('1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE));
        directed_rows.push_back(width_entry(7'd65));
        directed_rows.push_back(row_entry(64'h8000_0000_0000_0001, 1'b0));
        directed_rows.push_back(row_entry(64'hC000_0000_0000_0000, 1'b1));

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            s = directed_rows[i];
            if (s.kind == STIM_WIDTH)
                set_width(s.width);
            else
                push_row(s.cells, s.last, s.known, s.known_cells);
        end

        // Random phases: each starts with a width setting and then streams
        // generations of mixed height; a phase may end part-way through one.
        set_width(7'd64);
        while (rows_sent < RANDOM_ROWS + directed_rows.size()) begin
            remaining = $urandom_range(60, 250);
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            while (remaining > 0 && rows_sent < RANDOM_ROWS + directed_rows.size()) begin
                height = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                     : $urandom_range(1, 6);
                style  = $urandom_range(0, 5);
                for (int h = 0; h < height && remaining > 0; h++) begin
                    push_row(random_row(style), h == height - 1, 1'b0, '0);
                    remaining--;
                end
            end
            set_width(pick_width());
        end

        i_in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("Streamed %0d rows forming %0d complete generations over %0d width writes.",
                 rows_sent, generations_done, width_writes);
        $display("Checked %0d results, with one output hold-off of %0d cycles.",
                 results_checked, hold_cycles_seen);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Output side: short random pauses, and once a long hold-off so that the
    // result queue fills and the input is forced to stall.
    initial begin
        int  pause_left;
        int  hold_left;
        bit  long_hold_done;
        pause_left     = 0;
        hold_left      = 0;
        long_hold_done = 1'b0;
        i_out_ready    = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                hold_cycles_seen++;
                i_out_ready = 1'b0;
            end else if (!long_hold_done && results_checked >= 300) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                hold_cycles_seen++;
                i_out_ready    = 1'b0;
            end else if (pause_left > 0) begin
                pause_left--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = 1'b1;
                pause_left  = pick_pause(recv_calm);
            end
        end
    end

    // Each result transaction is compared with the oldest expectation.
    initial begin
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected result", o_next_row_cells, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_next_row_cells !== want.cells)
                        flag_mismatch("next_row_cells", o_next_row_cells, want.cells);
                    if (o_last_row_out !== want.last)
                        flag_mismatch("last_row_out", 64'(o_last_row_out), 64'(want.last));
                    results_checked++;
                end
            end
        end
    end

endmodule

FILE: life_generation_row_stepper_core.f
hdl/lgrs_pkg.sv
hdl/lgrs_cell.sv
hdl/lgrs_outq.sv
hdl/life_generation_row_stepper_core.sv
sim/tb.sv
